@@ rtl/core/grc_pkg.sv @@
// Package for the Gale-Ryser realisability check core.
// Holds the sizing constants and the walk accumulator type.
// Used by grc_hist_mem, grc_step_unit and gale_ryser_realizability_check_core.
package grc_pkg;

    localparam int MAX_SUM  = 64;
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int N_BINS   = MAX_SUM + 1;

    localparam int CNT_W  = 7;
    localparam int ADDR_W = $clog2(N_BINS);
    localparam int ACC_W  = $clog2(MAX_SUM * MAX_COLS + 1);

    typedef struct packed {
        logic [ACC_W-1:0] cum_col;
        logic [ACC_W-1:0] cum_conj;
        logic [CNT_W-1:0] below;
    } walk_acc_t;

endpackage

@@ rtl/core/grc_hist_mem.sv @@
// Histogram store: one bin per possible margin sum, registered read port.
// Per-bin valid flags make unwritten bins read as zero and let a clear empty every bin at once.
// Depends on grc_pkg.
module grc_hist_mem
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic [grc_pkg::ADDR_W-1:0] rd_addr,
    output logic [grc_pkg::CNT_W-1:0]  rd_data,
    input  logic                       wr_en,
    input  logic [grc_pkg::ADDR_W-1:0] wr_addr,
    input  logic [grc_pkg::CNT_W-1:0]  wr_data
);

    logic [grc_pkg::CNT_W-1:0]  mem [0:grc_pkg::N_BINS-1];
    logic [grc_pkg::N_BINS-1:0] valid_reg;
    logic [grc_pkg::CNT_W-1:0]  rd_data_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/grc_step_unit.sv @@
// Shared arithmetic step of the dominance walk: advances the prefix sums by one column.
// Purely combinational; the sequencer in the top level registers its result.
// Depends on grc_pkg.
module grc_step_unit
(
    input  grc_pkg::walk_acc_t         acc_in,
    input  logic [grc_pkg::CNT_W-1:0]  col_sum,
    input  logic [grc_pkg::CNT_W-1:0]  row_bin,
    input  logic [grc_pkg::CNT_W-1:0]  row_count,
    output grc_pkg::walk_acc_t         acc_out,
    output logic                       over
);

    logic [grc_pkg::CNT_W-1:0] below_new;
    logic [grc_pkg::CNT_W-1:0] conj_add;

    always_comb
    begin
        // Rows whose sum lies below the new column position drop out of the conjugate.
        below_new        = grc_pkg::CNT_W'(acc_in.below + row_bin);
        conj_add         = grc_pkg::CNT_W'(row_count - below_new);
        acc_out.below    = below_new;
        acc_out.cum_col  = grc_pkg::ACC_W'(acc_in.cum_col + grc_pkg::ACC_W'(col_sum));
        acc_out.cum_conj = grc_pkg::ACC_W'(acc_in.cum_conj + grc_pkg::ACC_W'(conj_add));
        over             = acc_out.cum_col > acc_out.cum_conj;
    end

endmodule

@@ rtl/core/gale_ryser_realizability_check_core.sv @@
// Gale-Ryser realisability check. Row and column sums stream in one item per
// clock while the block is idle; each kept item increments a histogram bin in a
// two-stage read-modify-write with forwarding. The item carrying tlast then
// starts the dominance walk unless a pre-check already fails: the column
// histogram is scanned from sum 64 down to 0, all through one shared
// adder/compare step unit, and the walk ends early on the first failing prefix.
// s_tready stays low from the last item until the result has entered the
// output register.
// Depends on grc_pkg, grc_hist_mem and grc_step_unit.
module gale_ryser_realizability_check_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,   // skip_rows
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [6:0] sum_value, [7] zero fill
    input  logic        s_tuser,    // is_column
    input  logic        s_tlast,    // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [0] realizable, [7:1] rows_used, [14:8] columns_used,
                                    // [15] overflow
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE      = 3'd0;
    localparam logic [ST_W-1:0] S_DRAIN     = 3'd1;
    localparam logic [ST_W-1:0] S_FETCH_COL = 3'd2;
    localparam logic [ST_W-1:0] S_WAIT_COL  = 3'd3;
    localparam logic [ST_W-1:0] S_ROWRD     = 3'd4;
    localparam logic [ST_W-1:0] S_STEP      = 3'd5;
    localparam logic [ST_W-1:0] S_DONE      = 3'd6;

    localparam int CW = grc_pkg::CNT_W;
    localparam int AW = grc_pkg::ADDR_W;

    logic [ST_W-1:0] state_reg, state_next;
    logic [CW-1:0]   skip_reg, skip_next;
    logic [CW-1:0]   row_count_reg, row_count_next;
    logic [CW-1:0]   col_count_reg, col_count_next;
    logic [CW-1:0]   skipped_reg, skipped_next;
    logic [CW-1:0]   max_row_reg, max_row_next;
    logic            bad_reg, bad_next;
    logic            range_reg, range_next;

    logic            pend_valid_reg, pend_valid_next;
    logic            pend_col_reg, pend_col_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic            lw_valid_reg, lw_valid_next;
    logic            lw_col_reg, lw_col_next;
    logic [AW-1:0]   lw_addr_reg, lw_addr_next;
    logic [CW-1:0]   lw_data_reg, lw_data_next;

    logic [CW-1:0]   v_reg, v_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   n_left_reg, n_left_next;
    grc_pkg::walk_acc_t acc_reg, acc_next;
    logic            real_reg, real_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [15:0]     m_tdata_reg, m_tdata_next;

    logic            accept;
    logic [CW-1:0]   sval;
    logic            in_range;
    logic            keep_row;
    logic [AW-1:0]   load_addr;
    logic            clear;
    logic [AW-1:0]   col_rd_addr, row_rd_addr;
    logic [CW-1:0]   col_rd_data, row_rd_data;
    logic [CW-1:0]   base_cnt, wr_cnt;
    logic            col_wr_en, row_wr_en;
    logic            pre_fail;
    logic            out_free;
    grc_pkg::walk_acc_t acc_step;
    logic            step_over;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign sval      = s_tdata[CW-1:0];
    assign in_range  = sval <= CW'(grc_pkg::MAX_SUM);
    assign keep_row  = skipped_reg >= skip_reg;
    assign load_addr = in_range ? AW'(sval) : '0;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign clear     = (state_reg == S_DONE) && out_free;
    assign pre_fail  = bad_reg || range_reg || (max_row_reg > col_count_reg);

    assign col_rd_addr = (state_reg == S_IDLE) ? load_addr : AW'(v_reg);
    assign row_rd_addr = (state_reg == S_IDLE) ? load_addr : AW'(k_reg);

    // Second half of the increment; the last write is forwarded because a read
    // issued in the same cycle as that write still sees the old bin.
    always_comb
    begin
        if (lw_valid_reg && (lw_col_reg == pend_col_reg) && (lw_addr_reg == pend_addr_reg))
        begin
            base_cnt = lw_data_reg;
        end
        else
        begin
            base_cnt = pend_col_reg ? col_rd_data : row_rd_data;
        end
        wr_cnt    = CW'(base_cnt + CW'(1));
        col_wr_en = pend_valid_reg && pend_col_reg;
        row_wr_en = pend_valid_reg && !pend_col_reg;
    end

    grc_hist_mem u_col_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .rd_addr (col_rd_addr),
        .rd_data (col_rd_data),
        .wr_en   (col_wr_en),
        .wr_addr (pend_addr_reg),
        .wr_data (wr_cnt)
    );

    grc_hist_mem u_row_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data),
        .wr_en   (row_wr_en),
        .wr_addr (pend_addr_reg),
        .wr_data (wr_cnt)
    );

    grc_step_unit u_step
    (
        .acc_in    (acc_reg),
        .col_sum   (v_reg),
        .row_bin   (row_rd_data),
        .row_count (row_count_reg),
        .acc_out   (acc_step),
        .over      (step_over)
    );

    always_comb
    begin
        state_next      = state_reg;
        skip_next       = skip_reg;
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        skipped_next    = skipped_reg;
        max_row_next    = max_row_reg;
        bad_next        = bad_reg;
        range_next      = range_reg;
        pend_valid_next = 1'b0;
        pend_col_next   = pend_col_reg;
        pend_addr_next  = pend_addr_reg;
        lw_valid_next   = lw_valid_reg;
        lw_col_next     = lw_col_reg;
        lw_addr_next    = lw_addr_reg;
        lw_data_next    = lw_data_reg;
        v_next          = v_reg;
        k_next          = k_reg;
        n_left_next     = n_left_reg;
        acc_next        = acc_reg;
        real_next       = real_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (cfg_valid && cfg_ready)
        begin
            skip_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (pend_valid_reg)
        begin
            lw_valid_next = 1'b1;
            lw_col_next   = pend_col_reg;
            lw_addr_next  = pend_addr_reg;
            lw_data_next  = wr_cnt;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_col_next  = s_tuser;
                    pend_addr_next = load_addr;
                    if (s_tuser)
                    begin
                        if (col_count_reg >= CW'(grc_pkg::MAX_COLS))
                        begin
                            bad_next = 1'b1;
                        end
                        else if (!in_range)
                        begin
                            range_next = 1'b1;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            col_count_next  = CW'(col_count_reg + CW'(1));
                        end
                    end
                    else if (!keep_row)
                    begin
                        skipped_next = CW'(skipped_reg + CW'(1));
                    end
                    else if (row_count_reg >= CW'(grc_pkg::MAX_ROWS))
                    begin
                        bad_next = 1'b1;
                    end
                    else if (!in_range)
                    begin
                        range_next = 1'b1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        row_count_next  = CW'(row_count_reg + CW'(1));
                        if (sval > max_row_reg)
                        begin
                            max_row_next = sval;
                        end
                    end
                    if (s_tlast)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end

            S_DRAIN:
            begin
                v_next   = CW'(grc_pkg::MAX_SUM);
                k_next   = '0;
                acc_next = '0;
                if (pre_fail)
                begin
                    real_next  = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FETCH_COL;
                end
            end

            S_FETCH_COL:
            begin
                state_next = S_WAIT_COL;
            end

            S_WAIT_COL:
            begin
                if (col_rd_data == '0)
                begin
                    if (v_reg == '0)
                    begin
                        real_next  = (acc_reg.cum_col == acc_reg.cum_conj);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        v_next     = CW'(v_reg - CW'(1));
                        state_next = S_FETCH_COL;
                    end
                end
                else
                begin
                    n_left_next = col_rd_data;
                    state_next  = S_ROWRD;
                end
            end

            S_ROWRD:
            begin
                state_next = S_STEP;
            end

            S_STEP:
            begin
                acc_next    = acc_step;
                k_next      = CW'(k_reg + CW'(1));
                n_left_next = CW'(n_left_reg - CW'(1));
                if (step_over)
                begin
                    real_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (n_left_reg == CW'(1))
                begin
                    if (v_reg == '0)
                    begin
                        real_next  = (acc_step.cum_col == acc_step.cum_conj);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        v_next     = CW'(v_reg - CW'(1));
                        state_next = S_FETCH_COL;
                    end
                end
                else
                begin
                    state_next = S_ROWRD;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = {bad_reg, col_count_reg, row_count_reg, real_reg};
                    row_count_next = '0;
                    col_count_next = '0;
                    skipped_next   = '0;
                    max_row_next   = '0;
                    bad_next       = 1'b0;
                    range_next     = 1'b0;
                    lw_valid_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            skip_reg       <= '0;
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            skipped_reg    <= '0;
            max_row_reg    <= '0;
            bad_reg        <= 1'b0;
            range_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            lw_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            skip_reg       <= skip_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            skipped_reg    <= skipped_next;
            max_row_reg    <= max_row_next;
            bad_reg        <= bad_next;
            range_reg      <= range_next;
            pend_valid_reg <= pend_valid_next;
            lw_valid_reg   <= lw_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_col_reg  <= pend_col_next;
        pend_addr_reg <= pend_addr_next;
        lw_col_reg    <= lw_col_next;
        lw_addr_reg   <= lw_addr_next;
        lw_data_reg   <= lw_data_next;
        v_reg         <= v_next;
        k_reg         <= k_next;
        n_left_reg    <= n_left_next;
        acc_reg       <= acc_next;
        real_reg      <= real_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken straight after the last item");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result produced outside the finishing state");

    a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (row_count_reg <= CW'(grc_pkg::MAX_ROWS)) && (col_count_reg <= CW'(grc_pkg::MAX_COLS)))
        else $error("margin count beyond its limit");

    a_walk_position: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWRD) |-> (k_reg < col_count_reg))
        else $error("walk position passed the column count");

    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_DRAIN) |-> !pend_valid_reg)
        else $error("histogram write pending during the walk");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for gale_ryser_realizability_check_core: streams row and column
// sums, predicts each realisability verdict and compares it with the block's result.
// Depends on grc_pkg and the core.
module tb;

    localparam int CLK_HALF = 6;
    localparam int SETTLE   = 300;

    typedef struct packed {
        bit       overflow;
        bit [6:0] columns_used;
        bit [6:0] rows_used;
        bit       realizable;
    } verdict_t;

    typedef struct packed {
        bit       is_col;
        bit [6:0] val;
    } margin_t;

    typedef enum int {SHAPE_CLEAN, SHAPE_NUDGE, SHAPE_NOISE, SHAPE_WIDE} shape_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [6:0] sum_value, [7] zero fill
    logic        s_tuser;      // is_column
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [0] realizable, [7:1] rows_used, [14:8] columns_used,
                               // [15] overflow

    // Shadow of the block's state.
    bit [6:0] skip_setting;
    bit [6:0] row_bins [0:grc_pkg::MAX_SUM];
    bit [6:0] col_bins [0:grc_pkg::MAX_SUM];
    bit [6:0] row_total;
    bit [6:0] col_total;
    bit [6:0] rows_skipped;
    bit       too_many;
    bit       out_of_range;

    verdict_t verdicts_due[$];
    int       mismatches;
    int       items_counted;
    int       send_burst;
    int       recv_burst;

    gale_ryser_realizability_check_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    function automatic void clear_tallies();
        int v;
        for (v = 0; v <= grc_pkg::MAX_SUM; v++)
        begin
            row_bins[v] = '0;
            col_bins[v] = '0;
        end
        row_total    = '0;
        col_total    = '0;
        rows_skipped = '0;
        too_many     = 1'b0;
        out_of_range = 1'b0;
    endfunction

    // Walks the column sums from the largest down and compares each prefix with
    // the matching prefix of the conjugate of the row sums.
    function automatic bit margins_realizable();
        int v;
        int n;
        int k;
        int below;
        int cum_col;
        int cum_conj;
        if (too_many || out_of_range)
            return 1'b0;
        for (v = 0; v <= grc_pkg::MAX_SUM; v++)
            if (v > col_total && row_bins[v] != 0)
                return 1'b0;
        k        = 0;
        below    = 0;
        cum_col  = 0;
        cum_conj = 0;
        for (v = grc_pkg::MAX_SUM; v >= 0; v--)
        begin
            for (n = 0; n < col_bins[v]; n++)
            begin
                k++;
                if (k - 1 <= grc_pkg::MAX_SUM)
                    below += row_bins[k - 1];
                cum_col  += v;
                cum_conj += row_total - below;
                if (cum_col > cum_conj)
                    return 1'b0;
            end
        end
        return cum_col == cum_conj;
    endfunction

    function automatic void tally_margin(bit is_col, bit [6:0] val, bit last);
        verdict_t v;
        if (is_col)
        begin
            if (col_total >= grc_pkg::MAX_COLS)
                too_many = 1'b1;
            else if (val > grc_pkg::MAX_SUM)
                out_of_range = 1'b1;
            else
            begin
                col_bins[val]++;
                col_total++;
            end
        end
        else if (rows_skipped < skip_setting)
            rows_skipped++;
        else
        begin
            if (row_total >= grc_pkg::MAX_ROWS)
                too_many = 1'b1;
            else if (val > grc_pkg::MAX_SUM)
                out_of_range = 1'b1;
            else
            begin
                row_bins[val]++;
                row_total++;
            end
        end
        if (last)
        begin
            v.realizable   = margins_realizable();
            v.rows_used    = row_total;
            v.columns_used = col_total;
            v.overflow     = too_many;
            verdicts_due.push_back(v);
            clear_tallies();
        end
    endfunction

    // Mostly short random waits, now and then a run of back-to-back items.
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic send_item(bit is_col, bit [6:0] val, bit last);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {1'b0, val};
        s_tuser  <= is_col;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
        items_counted++;
        tally_margin(is_col, val, last);
    endtask

    // Holds the sender back until every verdict has come out and the walk is over.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (verdicts_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_skip(bit [6:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid    <= 1'b0;
        skip_setting = value;
    endtask

    // Margins of a random 0/1 matrix, optionally spoilt, sent in shuffled order
    // after the row items that the block is set to discard.
    task automatic send_instance(int n_rows, int n_cols, shape_t shape);
        int       row_sum [70];
        int       col_sum [70];
        margin_t  batch[$];
        margin_t  m;
        int       i;
        int       j;
        int       density;
        for (i = 0; i < 70; i++)
        begin
            row_sum[i] = 0;
            col_sum[i] = 0;
        end
        density = $urandom_range(0, 100);
        for (i = 0; i < n_rows; i++)
            for (j = 0; j < n_cols; j++)
                if ($urandom_range(1, 100) <= density)
                begin
                    row_sum[i]++;
                    col_sum[j]++;
                end
        for (i = 0; i < n_rows; i++)
            batch.push_back({1'b0, 7'(row_sum[i])});
        for (j = 0; j < n_cols; j++)
            batch.push_back({1'b1, 7'(col_sum[j])});
        if (batch.size() == 0 && skip_setting == 0)
            batch.push_back({1'b0, 7'd0});
        if (batch.size() != 0)
        begin
            i = $urandom_range(0, batch.size() - 1);
            case (shape)
                SHAPE_NUDGE:
                    if (batch[i].val == 0 || $urandom_range(0, 1) == 1)
                        batch[i].val = batch[i].val + 7'd1;
                    else
                        batch[i].val = batch[i].val - 7'd1;
                SHAPE_NOISE:
                    for (j = 0; j < batch.size(); j++)
                        batch[j].val = batch[j].is_col ? 7'($urandom_range(0, n_rows + 1))
                                                       : 7'($urandom_range(0, n_cols + 1));
                SHAPE_WIDE:
                    batch[i].val = 7'($urandom_range(grc_pkg::MAX_SUM + 1, 127));
                default:
                    ;
            endcase
        end
        for (i = batch.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            m        = batch[i];
            batch[i] = batch[j];
            batch[j] = m;
        end
        for (i = 0; i < skip_setting; i++)
            send_item(1'b0, 7'($urandom_range(0, 127)),
                      i == skip_setting - 1 && batch.size() == 0);
        for (i = 0; i < batch.size(); i++)
            send_item(batch[i].is_col, batch[i].val, i == batch.size() - 1);
    endtask

    task automatic test_directed_margins();
        send_item(1'b0, 7'd0, 1'b1);       // zero-sum row with no columns
        send_item(1'b1, 7'd0, 1'b1);       // zero-sum column with no rows
        send_item(1'b0, 7'd1, 1'b0);
        send_item(1'b1, 7'd1, 1'b1);
        send_item(1'b0, 7'd2, 1'b0);       // row wider than the column count
        send_item(1'b1, 7'd1, 1'b1);
        send_item(1'b0, 7'd2, 1'b0);       // equal totals, dominance fails
        send_item(1'b0, 7'd2, 1'b0);
        send_item(1'b1, 7'd3, 1'b0);
        send_item(1'b1, 7'd1, 1'b1);
        send_item(1'b0, 7'd1, 1'b0);       // totals differ
        send_item(1'b1, 7'd0, 1'b1);
        send_item(1'b0, 7'd64, 1'b0);
        send_item(1'b1, 7'd1, 1'b1);
        send_item(1'b1, 7'd127, 1'b1);     // column sum out of range
        send_item(1'b0, 7'd65, 1'b0);      // row sum out of range
        send_item(1'b1, 7'd0, 1'b1);
        settle();
    endtask

    task automatic test_skipped_rows();
        write_skip(7'd2);
        send_item(1'b0, 7'd7, 1'b1);       // the last item is itself discarded
        send_item(1'b0, 7'd100, 1'b0);
        send_item(1'b1, 7'd1, 1'b0);
        send_item(1'b0, 7'd3, 1'b0);
        send_item(1'b0, 7'd1, 1'b1);
        settle();
    endtask

    task automatic test_random_instances(int target);
        int     start;
        int     pick;
        int     n_rows;
        int     n_cols;
        shape_t shape;
        start = items_counted;
        while (items_counted - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                n_rows = $urandom_range(grc_pkg::MAX_ROWS + 1, grc_pkg::MAX_ROWS + 4);
                n_cols = $urandom_range(0, 6);
                if ($urandom_range(0, 1) == 1)
                begin
                    n_cols = n_rows;
                    n_rows = $urandom_range(0, 6);
                end
            end
            else if (pick < 12)
            begin
                n_rows = $urandom_range(20, grc_pkg::MAX_ROWS);
                n_cols = $urandom_range(20, grc_pkg::MAX_COLS);
            end
            else
            begin
                n_rows = $urandom_range(0, 8);
                n_cols = $urandom_range(0, 8);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
                shape = SHAPE_CLEAN;
            else if (pick < 75)
                shape = SHAPE_NUDGE;
            else if (pick < 90)
                shape = SHAPE_NOISE;
            else
                shape = SHAPE_WIDE;
            send_instance(n_rows, n_cols, shape);
        end
        settle();
    endtask

    task automatic test_long_skips();
        write_skip(7'd64);
        send_instance(3, 4, SHAPE_CLEAN);
        send_instance(0, 0, SHAPE_CLEAN);
        settle();
        write_skip(7'd63);
        send_instance(5, 2, SHAPE_CLEAN);
        send_instance(2, 5, SHAPE_NOISE);
        settle();
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("result 0x%h arrived with no verdict pending", m_tdata);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[0] !== want.realizable)
                begin
                    $error("realizable: expected %0d, actual %0d", want.realizable, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[7:1] !== want.rows_used)
                begin
                    $error("rows_used: expected %0d, actual %0d", want.rows_used, m_tdata[7:1]);
                    mismatches++;
                end
                if (m_tdata[14:8] !== want.columns_used)
                begin
                    $error("columns_used: expected %0d, actual %0d",
                           want.columns_used, m_tdata[14:8]);
                    mismatches++;
                end
                if (m_tdata[15] !== want.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d", want.overflow, m_tdata[15]);
                    mismatches++;
                end
            end
        end
    end

    // Result side: random stalls between results, with runs of none.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(recv_burst);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    initial
    begin
        #(2 * CLK_HALF * 1000000);
        $display("tb failed");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        mismatches   = 0;
        items_counted = 0;
        send_burst   = 0;
        recv_burst   = 0;
        skip_setting = '0;
        clear_tallies();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_skip(7'd0);
        test_directed_margins();
        test_skipped_rows();
        write_skip(7'd0);
        test_random_instances(250);
        test_long_skips();
        write_skip(7'($urandom_range(1, 5)));
        test_random_instances(200);
        write_skip(7'd0);
        test_random_instances(200);

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
